FILE: hw/rtl/bkt_pkg.sv
`timescale 1ns / 1ps
// Package for the keyed table block: command and status codes, record type.
// No dependencies.
package bkt_pkg;
    localparam int DEPTH_DEF = 10;
    localparam int CMD_W = 3;
    localparam int NAME_W = 64;
    localparam int AMT_W = 32;
    localparam int POS_W = 4;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LIST   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LSRCH  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SORT   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BSRCH  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [NAME_W-1:0] kind;
        logic [AMT_W-1:0]  amount;
    } t_rec;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [NAME_W-1:0] key_name;
        logic [NAME_W-1:0] kind_tag;
        logic signed [AMT_W-1:0] amount;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [POS_W-1:0]  position;
        logic [NAME_W-1:0] out_name;
        logic [NAME_W-1:0] out_kind;
        logic signed [AMT_W-1:0] out_amount;
        logic [POS_W-1:0]  compare_count;
        logic              last;
    } t_out;
endpackage

FILE: hw/rtl/bkt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the keyed table block.
// Depends on bkt_pkg.
interface bkt_in_if import bkt_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bkt_out_if import bkt_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/bounded_keyed_table_sort_search.sv
`timescale 1ns / 1ps
// Top level of the keyed table block: record memory and command sequencer.
// Depends on bkt_pkg and bkt_if.
//
// Usage: commands arrive on i_cmd (valid/ready), results leave on o_res.
// The records sit in one memory with a registered read port;
// each command is run by a sequencer that reads, compares and writes back
// one entry per step. Append writes the record directly; remove, list
// and linear search read then act on each visited entry, and remove then
// shifts each later entry down with a read and a write; binary search
// reads then compares per probe; sort reads a pair, compares it and
// writes an out-of-order pair back swapped, one entry per write.
// One command is handled at a time; i_cmd.ready is high only in the idle
// state. Results go through one output register: the sequencer holds
// while the receiver stalls, and list results each wait their turn.
// Reset empties the table (count to zero) and drops any pending result;
// the memory contents are not cleared and no entry past the count is read.
// last marks the final result of each command.
module bounded_keyed_table_sort_search import bkt_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bkt_in_if.sink    i_cmd,
    bkt_out_if.source o_res
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_SHRD  = 4'd3;
    localparam logic [3:0] S_SHWR  = 4'd4;
    localparam logic [3:0] S_OUT   = 4'd5;
    localparam logic [3:0] S_SRDA  = 4'd6;
    localparam logic [3:0] S_SRDB  = 4'd7;
    localparam logic [3:0] S_SCMP  = 4'd8;
    localparam logic [3:0] S_SWB   = 4'd9;
    localparam logic [3:0] S_APP   = 4'd10;

    t_rec r_mem [DEPTH];
    t_rec r_rd;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    t_rec          mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[mem_ra];
    end

    logic [3:0]    r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_lim, n_lim;
    logic [CW:0]   r_lo, n_lo, r_hi, n_hi;
    logic [POS_W-1:0] r_cmps, n_cmps;
    t_in           r_in, n_in;
    t_rec          r_a, n_a;
    logic          r_ov, n_ov;
    t_out          r_o, n_o;

    logic out_free;
    logic [CW:0] mid;
    assign out_free = !r_ov || o_res.ready;
    assign mid = (r_lo + r_hi) >> 1;

    assign i_cmd.ready = (r_st == S_IDLE) && out_free;
    assign o_res.valid = r_ov;
    assign o_res.data  = r_o;

    function automatic t_out mk(input logic [1:0] st, input logic [CW-1:0] pos,
                                input t_rec rc, input logic [POS_W-1:0] c,
                                input logic fin);
        t_out o;
        o.status = st;
        o.position = (st == ST_OK) ? POS_W'(pos) : '0;
        o.out_name = (st == ST_OK) ? rc.name : '0;
        o.out_kind = (st == ST_OK) ? rc.kind : '0;
        o.out_amount = (st == ST_OK) ? $signed(rc.amount) : '0;
        o.compare_count = c;
        o.last = fin;
        return o;
    endfunction

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_i = r_i; n_lim = r_lim; n_lo = r_lo;
        n_hi = r_hi; n_cmps = r_cmps; n_in = r_in; n_a = r_a;
        n_ov = r_ov && !o_res.ready; n_o = r_o;
        mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = r_i[AW-1:0];
        case (r_st)
            S_IDLE: begin
                if (i_cmd.valid && i_cmd.ready) begin
                    n_in = i_cmd.data; n_i = '0; n_cmps = '0;
                    case (i_cmd.data.cmd)
                        CMD_APPEND: begin
                            if (r_cnt == CW'(DEPTH)) begin
                                n_ov = 1'b1; n_o = mk(ST_FULL, '0, '0, '0, 1'b1);
                            end else begin
                                n_st = S_APP;
                            end
                        end
                        CMD_REMOVE, CMD_LIST: begin
                            if (r_cnt == '0) begin
                                n_ov = 1'b1; n_o = mk(ST_EMPTY, '0, '0, '0, 1'b1);
                            end else begin
                                n_st = S_RD;
                            end
                        end
                        CMD_LSRCH: begin
                            if (r_cnt == '0) begin
                                n_ov = 1'b1; n_o = mk(ST_MISSING, '0, '0, '0, 1'b1);
                            end else begin
                                n_st = S_RD;
                            end
                        end
                        CMD_BSRCH: begin
                            if (r_cnt == '0) begin
                                n_ov = 1'b1; n_o = mk(ST_MISSING, '0, '0, '0, 1'b1);
                            end else begin
                                n_lo = '0; n_hi = (CW+1)'(r_cnt) - 1'b1;
                                n_i = CW'((CW+1)'(r_cnt - 1'b1) >> 1);
                                n_st = S_RD;
                            end
                        end
                        CMD_SORT: begin
                            if (r_cnt < CW'(2)) begin
                                n_ov = 1'b1; n_o = mk(ST_OK, '0, '0, '0, 1'b1);
                            end else begin
                                n_lim = r_cnt - 1'b1; n_st = S_SRDA;
                            end
                        end
                        default: begin
                            n_ov = 1'b1; n_o = mk(ST_OK, '0, '0, '0, 1'b1);
                        end
                    endcase
                end
            end
            S_APP: begin
                mem_we = 1'b1; mem_wa = r_cnt[AW-1:0];
                mem_wd = '{name: r_in.key_name, kind: r_in.kind_tag,
                           amount: r_in.amount};
                n_ov = 1'b1;
                n_o = mk(ST_OK, r_cnt, mem_wd, '0, 1'b1);
                n_cnt = r_cnt + 1'b1; n_st = S_IDLE;
            end
            S_RD: n_st = S_CHK;
            S_CHK: begin
                case (r_in.cmd)
                    CMD_LIST: begin
                        if (out_free) begin
                            n_ov = 1'b1;
                            n_o = mk(ST_OK, r_i, r_rd, '0, r_i + 1'b1 == r_cnt);
                            n_i = r_i + 1'b1;
                            n_st = (r_i + 1'b1 == r_cnt) ? S_IDLE : S_RD;
                        end
                    end
                    CMD_LSRCH: begin
                        if (r_rd.name == r_in.key_name) begin
                            n_o = mk(ST_OK, r_i, r_rd, r_cmps + 1'b1, 1'b1);
                            n_st = S_OUT;
                        end else if (r_i + 1'b1 == r_cnt) begin
                            n_o = mk(ST_MISSING, '0, '0, r_cmps + 1'b1, 1'b1);
                            n_st = S_OUT;
                        end else begin
                            n_i = r_i + 1'b1; n_st = S_RD;
                        end
                        n_cmps = r_cmps + 1'b1;
                    end
                    CMD_REMOVE: begin
                        if (r_rd.name == r_in.key_name) begin
                            n_o = mk(ST_OK, r_i, r_rd, '0, 1'b1);
                            n_ov = 1'b0; n_st = S_SHRD;
                        end else if (r_i + 1'b1 == r_cnt) begin
                            n_o = mk(ST_MISSING, '0, '0, '0, 1'b1);
                            n_st = S_OUT;
                        end else begin
                            n_i = r_i + 1'b1; n_st = S_RD;
                        end
                        if (r_rd.name == r_in.key_name) n_ov = r_ov && !o_res.ready;
                    end
                    default: begin
                        n_cmps = r_cmps + 1'b1;
                        if (r_rd.name == r_in.key_name) begin
                            n_o = mk(ST_OK, r_i, r_rd, r_cmps + 1'b1, 1'b1);
                            n_st = S_OUT;
                        end else begin
                            if (r_rd.name < r_in.key_name) n_lo = mid + 1'b1;
                            else n_hi = mid - 1'b1;
                            if ((r_rd.name < r_in.key_name) ? (mid + 1'b1 > r_hi)
                                    : (mid == '0 || r_lo > mid - 1'b1)) begin
                                n_o = mk(ST_MISSING, '0, '0, r_cmps + 1'b1, 1'b1);
                                n_st = S_OUT;
                            end else begin
                                n_i = (r_rd.name < r_in.key_name)
                                    ? CW'((mid + 1'b1 + r_hi) >> 1)
                                    : CW'((r_lo + mid - 1'b1) >> 1);
                                n_st = S_RD;
                            end
                        end
                    end
                endcase
            end
            S_SHRD: begin
                if (r_i + 1'b1 >= r_cnt) begin
                    n_cnt = r_cnt - 1'b1; n_st = S_OUT;
                end else begin
                    mem_ra = AW'(r_i + 1'b1); n_st = S_SHWR;
                end
            end
            S_SHWR: begin
                mem_we = 1'b1; mem_wa = r_i[AW-1:0]; mem_wd = r_rd;
                n_i = r_i + 1'b1; n_st = S_SHRD;
            end
            S_OUT: begin
                if (out_free) begin
                    n_ov = 1'b1; n_st = S_IDLE;
                end
            end
            S_SRDA: begin
                mem_ra = r_i[AW-1:0]; n_st = S_SRDB;
            end
            S_SRDB: begin
                n_a = r_rd; mem_ra = AW'(r_i + 1'b1); n_st = S_SCMP;
            end
            S_SCMP: begin
                if (r_a.name > r_rd.name) begin
                    mem_we = 1'b1; mem_wa = r_i[AW-1:0]; mem_wd = r_rd;
                    n_st = S_SWB;
                end else if (r_i + 1'b1 >= r_lim) begin
                    n_i = '0; n_lim = r_lim - 1'b1;
                    if (r_lim == CW'(1)) begin
                        n_o = mk(ST_OK, '0, '0, '0, 1'b1); n_st = S_OUT;
                    end else n_st = S_SRDA;
                end else begin
                    n_i = r_i + 1'b1; n_st = S_SRDA;
                end
            end
            S_SWB: begin
                mem_we = 1'b1; mem_wa = AW'(r_i + 1'b1); mem_wd = r_a;
                if (r_i + 1'b1 >= r_lim) begin
                    n_i = '0; n_lim = r_lim - 1'b1;
                    if (r_lim == CW'(1)) begin
                        n_o = mk(ST_OK, '0, '0, '0, 1'b1); n_st = S_OUT;
                    end else n_st = S_SRDA;
                end else begin
                    n_i = r_i + 1'b1; n_st = S_SRDA;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_ov <= n_ov;
        end
        r_i <= n_i; r_lim <= n_lim; r_lo <= n_lo; r_hi <= n_hi; r_cmps <= n_cmps;
        r_in <= n_in; r_a <= n_a; r_o <= n_o;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= CW'(DEPTH))
        else $error("count above depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !i_cmd.ready)
        else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_res.ready) |=> $stable(r_o))
        else $error("result changed while stalled");
endmodule
